[rtl/core/lhl_pkg.sv]
// Shared types, widths and codes for the lattice heuristic lookup unit.
package lhl_pkg;

    localparam int DIRECTIONS   = 8;
    localparam int DIR_W        = 3;
    localparam int COORD_W      = 10;
    localparam int ADDR_W       = 14;
    localparam int COST_W       = 24;
    localparam int EDGE_W       = 5;
    localparam int EDGE_MAX_DEF = 16;
    localparam int FRAC_W       = 8;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int SUM_W        = SQ_W + 1;
    localparam int RAD_W        = SUM_W + 2 * FRAC_W + 1;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int REM_W        = ROOT_W + 3;
    localparam int OUTQ_DEPTH   = 32;

    localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(16);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ADDR_W-1:0]  table_addr;
        logic [COST_W-1:0]  table_value;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [DIR_W-1:0]   start_dir;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [DIR_W-1:0]   end_dir;
    } t_lhl_req;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              from_table;
    } t_lhl_rsp;

    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
    } t_lhl_qry;

    typedef struct packed {
        logic              hit;
        logic [COST_W-1:0] word;
    } t_lhl_tag;

endpackage

[rtl/core/lhl_front.sv]
// Delta, heading mirror, table hit test and table access generation.
module lhl_front #(
    parameter int EDGE_MAX = lhl_pkg::EDGE_MAX_DEF,
    parameter int AW       = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  lhl_pkg::t_lhl_req         i_req,
    input  logic [lhl_pkg::EDGE_W-1:0] i_table_edge,
    output logic                      o_mem_we,
    output logic [AW-1:0]             o_mem_addr,
    output logic [lhl_pkg::COST_W-1:0] o_mem_wdata,
    output lhl_pkg::t_lhl_qry         o_qry
);
    import lhl_pkg::*;

    localparam int DEPTH = DIRECTIONS * DIRECTIONS * EDGE_MAX * EDGE_MAX;
    localparam int LW    = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam int EGW   = ($clog2(EDGE_MAX + 1) > EDGE_W) ? $clog2(EDGE_MAX + 1) : EDGE_W;

    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [DIR_W-1:0]   sd_x;
    logic [DIR_W-1:0]   ed_x;
    logic [DIR_W-1:0]   sd;
    logic [DIR_W-1:0]   ed;
    logic [EGW-1:0]     eff_edge;
    logic               hit;
    logic [AW-1:0]      qaddr;
    logic [LW-1:0]      load_ext;
    logic               in_range;
    logic               is_load;
    t_lhl_qry           r_qry;
    t_lhl_qry           n_qry;

    always_comb begin
        if (i_req.end_x >= i_req.start_x) begin
            dx   = i_req.end_x - i_req.start_x;
            sd_x = i_req.start_dir;
            ed_x = i_req.end_dir;
        end else begin
            dx   = i_req.start_x - i_req.end_x;
            sd_x = DIR_W'(4) - i_req.start_dir;
            ed_x = DIR_W'(4) - i_req.end_dir;
        end
        if (i_req.end_y >= i_req.start_y) begin
            dy = i_req.end_y - i_req.start_y;
            sd = sd_x;
            ed = ed_x;
        end else begin
            dy = i_req.start_y - i_req.end_y;
            sd = DIR_W'(0) - sd_x;
            ed = DIR_W'(0) - ed_x;
        end

        eff_edge = (EGW'(i_table_edge) > EGW'(EDGE_MAX)) ? EGW'(EDGE_MAX) : EGW'(i_table_edge);
        hit      = (dx < COORD_W'(eff_edge)) && (dy < COORD_W'(eff_edge));
        qaddr    = ((AW'(sd) * AW'(EDGE_MAX) + AW'(dx)) * AW'(EDGE_MAX) + AW'(dy))
                   * AW'(DIRECTIONS) + AW'(ed);

        load_ext = LW'(i_req.table_addr);
        in_range = load_ext < LW'(DEPTH);
        is_load  = (i_req.req_type == REQ_LOAD);

        o_mem_we    = i_vld && is_load && in_range;
        o_mem_addr  = is_load ? load_ext[AW-1:0] : qaddr;
        o_mem_wdata = i_req.table_value;

        n_qry.vld = i_vld && (i_req.req_type == REQ_QUERY);
        n_qry.hit = hit;
        n_qry.dx  = dx;
        n_qry.dy  = dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qry.vld <= 1'b0;
        end else begin
            r_qry.vld <= n_qry.vld;
        end
        r_qry.hit <= n_qry.hit;
        r_qry.dx  <= n_qry.dx;
        r_qry.dy  <= n_qry.dy;
    end

    assign o_qry = r_qry;

endmodule

[rtl/core/lhl_table.sv]
// Heuristic cost table: one synchronous memory with a registered read.
module lhl_table #(
    parameter int AW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_addr,
    input  logic [lhl_pkg::COST_W-1:0] i_wdata,
    output logic [lhl_pkg::COST_W-1:0] o_rdata
);
    import lhl_pkg::*;

    logic [COST_W-1:0] r_mem [2**AW];
    logic [COST_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/lhl_sqrt.sv]
// Pipelined Euclidean distance: squares, then one root bit per stage, then rounding.
module lhl_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [lhl_pkg::COORD_W-1:0] i_dx,
    input  logic [lhl_pkg::COORD_W-1:0] i_dy,
    input  lhl_pkg::t_lhl_tag          i_tag,
    output logic                       o_vld,
    output lhl_pkg::t_lhl_tag          o_tag,
    output logic [lhl_pkg::ROOT_W-1:0] o_root
);
    import lhl_pkg::*;

    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic              r_sq_vld;
    t_lhl_tag          r_sq_tag;

    logic [RAD_W-1:0]  r_rad  [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    logic              r_vld  [ROOT_W+1];
    t_lhl_tag          r_tag  [ROOT_W+1];

    logic [ROOT_W-1:0] r_out_root;
    logic              r_out_vld;
    t_lhl_tag          r_out_tag;

    logic [SUM_W-1:0]  sum;

    assign sum = SUM_W'(r_sqx) + SUM_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_vld[0] <= 1'b0;
        end else begin
            r_sq_vld <= i_vld;
            r_vld[0] <= r_sq_vld;
        end
        r_sqx     <= i_dx * i_dx;
        r_sqy     <= i_dy * i_dy;
        r_sq_tag  <= i_tag;
        r_rad[0]  <= RAD_W'(sum) << (2 * FRAC_W);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_tag[0]  <= r_sq_tag;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb begin
            cur   = {r_rem[k][REM_W-3:0], r_rad[k][RAD_W-1 -: 2]};
            trial = REM_W'({r_root[k], 2'b01});
            ge    = cur >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= ge ? (cur - trial) : cur;
            r_root[k+1] <= {r_root[k][ROOT_W-2:0], ge};
            r_rad[k+1]  <= r_rad[k] << 2;
            r_tag[k+1]  <= r_tag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[ROOT_W];
        end
        r_out_root <= (r_rem[ROOT_W] > REM_W'(r_root[ROOT_W])) ?
                      (r_root[ROOT_W] + ROOT_W'(1)) : r_root[ROOT_W];
        r_out_tag  <= r_tag[ROOT_W];
    end

    assign o_vld  = r_out_vld;
    assign o_tag  = r_out_tag;
    assign o_root = r_out_root;

endmodule

[rtl/core/lhl_outq.sv]
// Result queue that decouples the pipeline from the output handshake.
module lhl_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lhl_pkg::t_lhl_rsp i_data,
    output logic              o_valid,
    input  logic              i_pop,
    output lhl_pkg::t_lhl_rsp o_data
);
    import lhl_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    t_lhl_rsp       r_mem [OUTQ_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < CW'(OUTQ_DEPTH)))
        else $error("Result queue written while full.");
`endif

endmodule

[rtl/core/lattice_heuristic_lookup_unit.sv]
// Top level of the lattice heuristic lookup unit.
//
//  Channel   Direction  Handshake            Payload
//  request   in         i_valid / o_ready    i_req  (t_lhl_req)
//  result    out        o_valid / i_ready    o_rsp  (t_lhl_rsp)
//  config    in         i_cfg_we             i_cfg_wdata (table edge)
//
// One transaction is accepted per cycle while o_ready is high.
// Latency is set by the square root pipeline, which resolves one root bit per stage.
// Table loads and lookups both access the memory at the same stage, so they stay ordered.
// A 32-entry result queue with credit counting stalls the input only when it would fill.
// Reset is synchronous and active low; the table contents are not cleared.
module lattice_heuristic_lookup_unit #(
    parameter int EDGE_MAX = lhl_pkg::EDGE_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  lhl_pkg::t_lhl_req          i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output lhl_pkg::t_lhl_rsp          o_rsp,
    input  logic                       i_cfg_we,
    input  logic [lhl_pkg::EDGE_W-1:0] i_cfg_wdata
);
    import lhl_pkg::*;

    localparam int AW = $clog2(DIRECTIONS * DIRECTIONS * EDGE_MAX * EDGE_MAX);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    logic [EDGE_W-1:0] r_table_edge;
    t_lhl_req          r_s0;
    logic              r_s0_vld;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     n_used;

    logic              accept;
    logic              pop;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [COST_W-1:0] mem_wdata;
    logic [COST_W-1:0] mem_rdata;
    t_lhl_qry          qry;
    t_lhl_tag          qry_tag;
    logic              sq_vld;
    t_lhl_tag          sq_tag;
    logic [ROOT_W-1:0] sq_root;
    t_lhl_rsp          rsp;

    assign o_ready = (r_used < CW'(OUTQ_DEPTH));
    assign accept  = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign n_used  = r_used + CW'(accept && (i_req.req_type == REQ_QUERY)) - CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_edge <= EDGE_RESET;
            r_s0_vld     <= 1'b0;
            r_used       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_edge <= i_cfg_wdata;
            end
            r_s0_vld <= accept;
            r_used   <= n_used;
        end
        if (accept) begin
            r_s0 <= i_req;
        end
    end

    lhl_front #(
        .EDGE_MAX (EDGE_MAX),
        .AW       (AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_s0_vld),
        .i_req        (r_s0),
        .i_table_edge (r_table_edge),
        .o_mem_we     (mem_we),
        .o_mem_addr   (mem_addr),
        .o_mem_wdata  (mem_wdata),
        .o_qry        (qry)
    );

    lhl_table #(
        .AW (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign qry_tag.hit  = qry.hit;
    assign qry_tag.word = mem_rdata;

    lhl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (qry.vld),
        .i_dx    (qry.dx),
        .i_dy    (qry.dy),
        .i_tag   (qry_tag),
        .o_vld   (sq_vld),
        .o_tag   (sq_tag),
        .o_root  (sq_root)
    );

    assign rsp.cost       = sq_tag.hit ? sq_tag.word : COST_W'(sq_root);
    assign rsp.from_table = sq_tag.hit;

    lhl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sq_vld),
        .i_data  (rsp),
        .o_valid (o_valid),
        .i_pop   (i_ready),
        .o_data  (o_rsp)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(OUTQ_DEPTH))
        else $error("Outstanding query count exceeds the result queue depth.");

    a_queued_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_used != '0))
        else $error("A result is queued without an outstanding query.");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_vld && (r_s0.req_type == REQ_LOAD)) |=> !qry.vld)
        else $error("A table load produced a query in the pipeline.");
`endif

endmodule

[tb/tb_lattice_heuristic_lookup_unit.sv]
// Self-checking testbench for the lattice heuristic lookup unit: table loads, lookups and fallback.
module tb_lattice_heuristic_lookup_unit;
    import lhl_pkg::*;

    localparam int PIPE_LAT    = 24;
    localparam int SETTLE      = PIPE_LAT + 8;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TABLE_WORDS = 1 << ADDR_W;
    localparam int COORD_TOP   = (1 << COORD_W) - 1;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_ready;
    t_lhl_req           i_req       = '0;
    logic               o_valid;
    logic               i_ready     = 1'b0;
    t_lhl_rsp           o_rsp;
    logic               i_cfg_we    = 1'b0;
    logic [EDGE_W-1:0]  i_cfg_wdata = '0;

    logic [COST_W-1:0]  cost_mem [TABLE_WORDS];
    bit                 slot_loaded [TABLE_WORDS];
    logic [EDGE_W-1:0]  model_edge   = EDGE_RESET;
    logic [EDGE_W-1:0]  edge_setting = EDGE_RESET;
    t_lhl_rsp           pending_costs [$];
    int                 cost_mismatches = 0;
    int                 quiet_cycles    = 0;
    int                 rx_hold         = 0;
    bit                 tx_steady       = 1'b0;
    bit                 rx_steady       = 1'b0;

    lattice_heuristic_lookup_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic lattice_span(input t_lhl_req r, input logic [EDGE_W-1:0] edge_v,
                                          output logic [ADDR_W-1:0] slot,
                                          output int unsigned dx, output int unsigned dy);
        logic [DIR_W-1:0] sd;
        logic [DIR_W-1:0] ed;
        int unsigned      lim;
        sd = r.start_dir;
        ed = r.end_dir;
        if (r.end_x >= r.start_x) begin
            dx = r.end_x - r.start_x;
        end else begin
            dx = r.start_x - r.end_x;
            sd = DIR_W'(4 - int'(sd));
            ed = DIR_W'(4 - int'(ed));
        end
        if (r.end_y >= r.start_y) begin
            dy = r.end_y - r.start_y;
        end else begin
            dy = r.start_y - r.end_y;
            sd = DIR_W'(0 - int'(sd));
            ed = DIR_W'(0 - int'(ed));
        end
        lim  = (edge_v > EDGE_MAX_DEF) ? EDGE_MAX_DEF : edge_v;
        slot = ADDR_W'(((int'(sd) * EDGE_MAX_DEF + dx) * EDGE_MAX_DEF + dy) * DIRECTIONS
                       + int'(ed));
        return (dx < lim) && (dy < lim);
    endfunction

    function automatic logic [COST_W-1:0] euclid_cost(input int unsigned dx,
                                                      input int unsigned dy);
        longint unsigned rad;
        longint unsigned root;
        longint unsigned trial;
        rad  = (longint'(dx) * dx + longint'(dy) * dy) << (2 * FRAC_W);
        root = 0;
        for (int b = 24; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= rad) root = trial;
        end
        if (rad - root * root > root) root++;
        if (root > 64'hFFFFFF) root = 64'hFFFFFF;
        return root[COST_W-1:0];
    endfunction

    function automatic t_lhl_rsp predict_cost(input t_lhl_req r);
        t_lhl_rsp          p;
        logic [ADDR_W-1:0] slot;
        int unsigned       dx;
        int unsigned       dy;
        if (lattice_span(r, model_edge, slot, dx, dy)) begin
            p.cost       = cost_mem[slot];
            p.from_table = 1'b1;
        end else begin
            p.cost       = euclid_cost(dx, dy);
            p.from_table = 1'b0;
        end
        return p;
    endfunction

    always @(posedge i_clk) begin : track_costs
        t_lhl_rsp want;
        if (!i_rst_n) begin
            model_edge = EDGE_RESET;
            pending_costs.delete();
        end else begin
            if (i_cfg_we) model_edge = i_cfg_wdata;
            if (o_valid && i_ready) begin
                if (pending_costs.size() == 0) begin
                    cost_mismatches++;
                    if (cost_mismatches <= 10)
                        $display("unexpected transaction: cost=%h from_table=%b",
                                 o_rsp.cost, o_rsp.from_table);
                end else begin
                    want = pending_costs.pop_front();
                    if (o_rsp.cost !== want.cost || o_rsp.from_table !== want.from_table) begin
                        cost_mismatches++;
                        if (cost_mismatches <= 10)
                            $display("mismatch: expected cost=%h from_table=%b, got cost=%h %s%b",
                                     want.cost, want.from_table, o_rsp.cost, "from_table=",
                                     o_rsp.from_table);
                    end
                end
            end
            if (i_valid && o_ready) begin
                if (i_req.req_type == REQ_LOAD)
                    cost_mem[i_req.table_addr] = i_req.table_value;
                else
                    pending_costs = {pending_costs, predict_cost(i_req)};
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("lattice_heuristic_lookup_unit regression: fail");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 8);
            end
        end
    end

    function automatic t_lhl_req random_fields();
        t_lhl_req r;
        r.req_type    = 1'($urandom);
        r.table_addr  = ADDR_W'($urandom);
        r.table_value = COST_W'($urandom);
        r.start_x     = COORD_W'($urandom);
        r.start_y     = COORD_W'($urandom);
        r.start_dir   = DIR_W'($urandom);
        r.end_x       = COORD_W'($urandom);
        r.end_y       = COORD_W'($urandom);
        r.end_dir     = DIR_W'($urandom);
        return r;
    endfunction

    function automatic t_lhl_req make_load(input logic [ADDR_W-1:0] addr,
                                           input logic [COST_W-1:0] value);
        t_lhl_req r;
        r             = random_fields();
        r.req_type    = REQ_LOAD;
        r.table_addr  = addr;
        r.table_value = value;
        return r;
    endfunction

    function automatic t_lhl_req make_query(input int sx, input int sy, input int sd,
                                            input int ex, input int ey, input int ed);
        t_lhl_req r;
        r           = random_fields();
        r.req_type  = REQ_QUERY;
        r.start_x   = COORD_W'(sx);
        r.start_y   = COORD_W'(sy);
        r.start_dir = DIR_W'(sd);
        r.end_x     = COORD_W'(ex);
        r.end_y     = COORD_W'(ey);
        r.end_dir   = DIR_W'(ed);
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base,
                                                      input int span);
        int v;
        v = int'(base) + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > COORD_TOP) v = COORD_TOP;
        return COORD_W'(v);
    endfunction

    function automatic t_lhl_req random_query();
        t_lhl_req r;
        r          = random_fields();
        r.req_type = REQ_QUERY;
        if ($urandom_range(99) < 70) begin
            r.end_x = near_coord(r.start_x, 18);
            r.end_y = near_coord(r.start_y, 18);
        end
        return r;
    endfunction

    task automatic send_item(input t_lhl_req r);
        int gap;
        gap = (!tx_steady && $urandom_range(99) < 8) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        if (r.req_type == REQ_LOAD) slot_loaded[r.table_addr] = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic issue_query(input t_lhl_req r);
        logic [ADDR_W-1:0] slot;
        int unsigned       dx;
        int unsigned       dy;
        if (lattice_span(r, edge_setting, slot, dx, dy) && !slot_loaded[slot])
            send_item(make_load(slot, COST_W'($urandom)));
        send_item(r);
    endtask

    task automatic random_items(input int count);
        repeat (count) begin
            if ($urandom_range(99) < 25)
                send_item(make_load(ADDR_W'($urandom), COST_W'($urandom)));
            else
                issue_query(random_query());
        end
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_edge(input logic [EDGE_W-1:0] v);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        edge_setting  = v;
        @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_item(make_load(ADDR_W'(0), COST_W'(0)));
        send_item(make_load({ADDR_W{1'b1}}, {COST_W{1'b1}}));
        issue_query(make_query(0, 0, 0, 0, 0, 0));
        issue_query(make_query(0, 0, 7, 15, 15, 7));
        issue_query(make_query(20, 30, 1, 5, 30, 6));
        issue_query(make_query(20, 30, 2, 20, 14, 3));
        issue_query(make_query(20, 30, 2, 20, 15, 3));
        issue_query(make_query(10, 10, 1, 7, 5, 6));
        issue_query(make_query(0, 0, 0, COORD_TOP, COORD_TOP, 7));
        issue_query(make_query(COORD_TOP, COORD_TOP, 5, 0, 0, 3));
        issue_query(make_query(0, COORD_TOP, 4, COORD_TOP, 0, 4));
        issue_query(make_query(500, 500, 3, 516, 500, 3));
        issue_query(make_query(500, 500, 0, 515, 500, 0));
        issue_query(make_query(COORD_TOP, 0, 7, COORD_TOP, 0, 0));
        send_item(make_load({ADDR_W{1'b1}}, COST_W'(0)));
        issue_query(make_query(3, 3, 7, 18, 18, 7));
        write_edge(EDGE_W'(0));
        issue_query(make_query(0, 0, 0, 0, 0, 0));
        issue_query(make_query(40, 40, 6, 41, 39, 2));
    endtask

    task automatic test_edge_settings();
        logic [EDGE_W-1:0] settings [6];
        settings = '{EDGE_W'(0), EDGE_W'(1), EDGE_W'(17), {EDGE_W{1'b1}}, EDGE_RESET,
                     EDGE_W'(0)};
        settings[5] = EDGE_W'($urandom_range(15, 2));
        foreach (settings[i]) begin
            write_edge(settings[i]);
            random_items(40);
        end
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            write_edge(EDGE_W'($urandom_range(16, 2)));
            tx_steady = (ph == 2);
            rx_steady = (ph == 2);
            random_items(230);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        rx_hold   = HOLD_CYCLES;
        tx_steady = 1'b1;
        repeat (80) issue_query(random_query());
        tx_steady = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_edge_settings();
        test_random_traffic();
        test_backpressure();
        settle_block();
        if (cost_mismatches == 0)
            $display("lattice_heuristic_lookup_unit regression: pass");
        else
            $display("lattice_heuristic_lookup_unit regression: fail");
        $finish;
    end

endmodule
